// ===== src/elc_pkg.sv =====
// shared types, constants and code point tables for the ebu latin to utf-8 converter
// no dependencies; imported by every module of the block
package elc_pkg;

	localparam logic [3:0] CHARSET_EBU_LATIN = 4'h0;
	localparam logic [3:0] CHARSET_UTF8      = 4'hF;

	// register select on paddr[2]
	localparam logic REG_CHARSET_MODE = 1'b0;

	localparam int ELC_QUEUE_DEPTH = 4;

	// one classified input: up to three utf-8 bytes, count zero marks a bare end marker
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      count;
		logic            fin;
	} elc_item_t;

	localparam logic [15:0] LOW_ROM [0:31] = '{
		16'h0000, 16'h0118, 16'h012E, 16'h0172, 16'h0102, 16'h0116, 16'h010E, 16'h0218,
		16'h021A, 16'h010A, 16'h0000, 16'h0000, 16'h0120, 16'h0139, 16'h017B, 16'h0143,
		16'h0105, 16'h0119, 16'h012F, 16'h0173, 16'h0103, 16'h0117, 16'h010F, 16'h0219,
		16'h021B, 16'h010B, 16'h0147, 16'h011A, 16'h0121, 16'h013A, 16'h017C, 16'h0000
	};

	// code points for bytes 0x7b to 0xff
	localparam logic [15:0] HIGH_ROM [0:132] = '{
		16'h00AB, 16'h016F, 16'h00BB, 16'h013D, 16'h0126,
		16'h00E1, 16'h00E0, 16'h00E9, 16'h00E8, 16'h00ED, 16'h00EC, 16'h00F3, 16'h00F2,
		16'h00FA, 16'h00F9, 16'h00D1, 16'h00C7, 16'h015E, 16'h00DF, 16'h00A1, 16'h0178,
		16'h00E2, 16'h00E4, 16'h00EA, 16'h00EB, 16'h00EE, 16'h00EF, 16'h00F4, 16'h00F6,
		16'h00FB, 16'h00FC, 16'h00F1, 16'h00E7, 16'h015F, 16'h011F, 16'h0131, 16'h00FF,
		16'h0136, 16'h0145, 16'h00A9, 16'h0122, 16'h011E, 16'h011B, 16'h0148, 16'h0151,
		16'h0150, 16'h20AC, 16'h00A3, 16'h0024, 16'h0100, 16'h0112, 16'h012A, 16'h016A,
		16'h0137, 16'h0146, 16'h013B, 16'h0123, 16'h013C, 16'h0130, 16'h0144, 16'h0171,
		16'h0170, 16'h00BF, 16'h013E, 16'h00B0, 16'h0101, 16'h0113, 16'h012B, 16'h016B,
		16'h00C1, 16'h00C0, 16'h00C9, 16'h00C8, 16'h00CD, 16'h00CC, 16'h00D3, 16'h00D2,
		16'h00DA, 16'h00D9, 16'h0158, 16'h010C, 16'h0160, 16'h017D, 16'h00D0, 16'h013F,
		16'h00C2, 16'h00C4, 16'h00CA, 16'h00CB, 16'h00CE, 16'h00CF, 16'h00D4, 16'h00D6,
		16'h00DB, 16'h00DC, 16'h0159, 16'h010D, 16'h0161, 16'h017E, 16'h0111, 16'h0140,
		16'h00C3, 16'h00C5, 16'h00C6, 16'h0152, 16'h0177, 16'h00DD, 16'h00D5, 16'h00D8,
		16'h00DE, 16'h014A, 16'h0154, 16'h0106, 16'h015A, 16'h0179, 16'h0164, 16'h00F0,
		16'h00E3, 16'h00E5, 16'h00E6, 16'h0153, 16'h0175, 16'h00FD, 16'h00F5, 16'h00F8,
		16'h00FE, 16'h014B, 16'h0155, 16'h0107, 16'h015B, 16'h017A, 16'h0165, 16'h0127
	};

	localparam logic [7:0] HIGH_BASE = 8'h7B;

	function automatic logic [15:0] ebu_code_point(input logic [7:0] b);
		logic [15:0] cp;
		logic [7:0]  hi_idx;
		hi_idx = b - HIGH_BASE;
		if (b <= 8'h1F) begin
			cp = LOW_ROM[b[4:0]];
		end else if (b >= HIGH_BASE) begin
			cp = HIGH_ROM[hi_idx];
		end else begin
			unique case (b)
				8'h24:   cp = 16'h0142;
				8'h5C:   cp = 16'h016E;
				8'h5E:   cp = 16'h0141;
				8'h60:   cp = 16'h0104;
				default: cp = {8'h00, b};
			endcase
		end
		return cp;
	endfunction

endpackage

// ===== src/elc_front.sv =====
// front end: maps ebu latin words to code points and encodes them as utf-8, passes
// utf-8 words through; depends on elc_pkg; feeds elc_queue
module elc_front (
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        text_byte,
	input  logic              final_byte,
	input  logic [3:0]        charset_mode,
	input  logic              queue_full,
	output logic              push,
	output elc_pkg::elc_item_t item
);
	import elc_pkg::*;

	logic        dropped;
	logic [15:0] cp;

	assign dropped = (text_byte == 8'h00) || (text_byte == 8'h0A) ||
		(text_byte == 8'h0B) || (text_byte == 8'h1F);
	assign cp = ebu_code_point(text_byte);

	always_comb begin
		item.bytes = '0;
		item.count = 2'd0;
		item.fin   = final_byte;
		if (!dropped) begin
			if (charset_mode == CHARSET_EBU_LATIN) begin
				if (cp == 16'h0000) begin
					item.count = 2'd0;
				end else if (cp < 16'h0080) begin
					item.bytes[0] = cp[7:0];
					item.count    = 2'd1;
				end else if (cp < 16'h0800) begin
					item.bytes[0] = {3'b110, cp[10:6]};
					item.bytes[1] = {2'b10, cp[5:0]};
					item.count    = 2'd2;
				end else begin
					item.bytes[0] = {4'b1110, cp[15:12]};
					item.bytes[1] = {2'b10, cp[11:6]};
					item.bytes[2] = {2'b10, cp[5:0]};
					item.count    = 2'd3;
				end
			end else if (charset_mode == CHARSET_UTF8) begin
				item.bytes[0] = text_byte;
				item.count    = 2'd1;
			end
		end
	end

	assign in_ready = !queue_full;
	// a non-final word that yields nothing leaves no trace
	assign push = in_valid && in_ready && ((item.count != 2'd0) || final_byte);

endmodule

// ===== src/elc_queue.sv =====
// short queue of classified items between the front and back ends
// depends on elc_pkg
module elc_queue #(
	parameter int DEPTH = elc_pkg::ELC_QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  elc_pkg::elc_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               head_valid,
	output elc_pkg::elc_item_t head_item
);
	import elc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	elc_item_t        mem_q [0:DEPTH-1];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(DEPTH - 1)) r = '0;
		else r = p + PTR_W'(1);
		return r;
	endfunction

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop) count_q <= count_q + CNT_W'(1);
			else if (pop && !push) count_q <= count_q - CNT_W'(1);
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("pop from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH)) else $error("queue count overflow");

endmodule

// ===== src/elc_back.sv =====
// back end: serialises queued items into output words, one byte per cycle
// while m_tready is high; depends on elc_pkg; reads the head of elc_queue
module elc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  elc_pkg::elc_item_t head_item,
	output logic               pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,
	output logic [1:0]         m_tuser,
	output logic               m_tlast
);
	import elc_pkg::*;

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_present_q;
	logic       out_run_end_q;
	logic       out_text_end_q;

	logic       load;
	logic       empty_marker;
	logic       last_byte;

	assign load         = head_valid && (!out_valid_q || m_tready);
	assign empty_marker = (head_item.count == 2'd0);
	assign last_byte    = empty_marker || (idx_q == head_item.count - 2'd1);
	assign pop          = load && last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= last_byte ? 2'd0 : idx_q + 2'd1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q     <= empty_marker ? 8'h00 : head_item.bytes[idx_q];
			out_present_q  <= !empty_marker;
			out_run_end_q  <= last_byte;
			out_text_end_q <= last_byte && head_item.fin;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = {out_run_end_q, out_present_q};
	assign m_tlast  = out_text_end_q;

	a_idx_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != 2'd0) |-> head_valid) else $error("byte index without an item");
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(head_valid && idx_q != 2'd0) |-> (idx_q < head_item.count))
		else $error("byte index past item length");
	a_text_end_on_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[1]) else $error("text end off a run end");

endmodule

// ===== src/ebu_latin_to_utf8_converter_unit.sv =====
// top level of the ebu latin to utf-8 converter: apb register, front end, queue, back end
// depends on elc_pkg, elc_front, elc_queue, elc_back
//
// usage
//   s_axis: one text byte per word in s_tdata[7:0], s_tlast on the last byte of the text.
//   m_axis: one utf-8 byte per word in m_tdata[7:0]; m_tuser[0] says the byte is present
//     (clear on a bare end marker), m_tuser[1] marks the last word caused by one input word,
//     m_tlast marks the last word of the whole text.
//   apb: one register, charset_mode at address 0 (0 ebu latin, 15 utf-8 passthrough,
//     other codes emit nothing); write it only while the block is empty.
// path: input words pass through the queue, then from its head into the output register.
// throughput: while m_tready is high the output side moves one byte per cycle, and an input
//   word expanding to n bytes (one to three) gives n output words; the input side takes
//   a word every cycle while the queue between front and back end has room.
// stalls: with m_tready low the output register holds; the queue keeps filling until
//   full, then s_tready drops. nothing is lost or repeated.
// reset: arst_n empties the queue and output register and sets charset_mode to 0.
module ebu_latin_to_utf8_converter_unit #(
	parameter int QUEUE_DEPTH = elc_pkg::ELC_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] utf8_byte
	output logic [1:0]  m_tuser,   // [0] byte_present, [1] run_end
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import elc_pkg::*;

	logic [3:0] charset_mode_q;
	logic       cfg_write;
	logic       queue_full;
	logic       push;
	logic       pop;
	logic       head_valid;
	elc_item_t  push_item;
	elc_item_t  head_item;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == REG_CHARSET_MODE) ? {28'd0, charset_mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			charset_mode_q <= CHARSET_EBU_LATIN;
		end else if (cfg_write && paddr[2] == REG_CHARSET_MODE) begin
			charset_mode_q <= pwdata[3:0];
		end
	end

	elc_front u_front (
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.text_byte    (s_tdata),
		.final_byte   (s_tlast),
		.charset_mode (charset_mode_q),
		.queue_full   (queue_full),
		.push         (push),
		.item         (push_item)
	);

	elc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	elc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule
